[rtl/core/ray_triangle_intersect_defines.svh]
// Assertion macros used by the port-level checker of the ray/triangle block.
`ifndef RAY_TRIANGLE_INTERSECT_DEFINES_SVH
`define RAY_TRIANGLE_INTERSECT_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define RTI_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Implication that looks ahead by the delay given in dly.
`define RTI_ASSERT_DELAY(lbl, clk, rst_n, ante, dly, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##dly (cons)) \
    else $error(msg);

`endif

[rtl/core/rti_pkg.sv]
// Types and constants shared by the ray/triangle intersection block.
package rti_pkg;

  localparam int DIST_W     = 24;
  localparam int CFG_W      = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int SLOT_W     = 2;
  localparam int DOT_W      = 64;
  localparam int GEOM_STAGES = 5;
  localparam int DIV_STAGES = DIST_W;
  // accept edge to result edge
  localparam int LATENCY    = GEOM_STAGES + 1 + DIV_STAGES + 1;

  typedef enum logic {
    ACT_LOAD = 1'b0,
    ACT_RAY  = 1'b1
  } action_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PARALLEL_EPS = 2'd0,
    REG_MIN_DIST     = 2'd1
  } cfg_reg_t;

  localparam logic [SLOT_W-1:0] SLOT_NONE = 2'd3;

  typedef struct packed {
    logic                    vld;
    logic signed [DOT_W-1:0] a;
    logic signed [DOT_W-1:0] un;
    logic signed [DOT_W-1:0] vn;
    logic signed [DOT_W-1:0] tn;
  } geom_res_t;

  typedef struct packed {
    logic              vld;
    logic              pass;
    logic [DIST_W-1:0] quo;
  } div_res_t;

endpackage

[rtl/core/ray_triangle_intersect.sv]
// Top level of the pipelined Moller-Trumbore ray/triangle intersection block.
// Load transactions (in_action 0) write one triangle corner, or none for slot
// 3, and give no result; ray transactions (in_action 1) give exactly one
// result, on out_valid for one cycle, after passing through the edge, cross
// and dot product arithmetic, a registered step of sign fixing and range
// tests, a one-bit-per-stage divider for the distance, and one output register.
// One transaction is accepted every cycle; busy is high only during reset, and
// the receiver cannot hold results off. A ray sees every corner loaded by an
// earlier transaction, including the one just before it. After reset all
// corners are zero, so rays miss until a triangle is loaded. Configuration
// writes are taken at any time but are meant for an idle block.
module ray_triangle_intersect import rti_pkg::*; #(
  parameter int COORD_WIDTH = 24,
  parameter int DIR_WIDTH   = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic                          in_action,
  input  logic [SLOT_W-1:0]             in_corner_slot,
  input  logic signed [COORD_WIDTH-1:0] in_point_x,
  input  logic signed [COORD_WIDTH-1:0] in_point_y,
  input  logic signed [COORD_WIDTH-1:0] in_point_z,
  input  logic signed [DIR_WIDTH-1:0]   in_dir_x,
  input  logic signed [DIR_WIDTH-1:0]   in_dir_y,
  input  logic signed [DIR_WIDTH-1:0]   in_dir_z,
  output logic                          out_valid,
  output logic                          out_hit,
  output logic [DIST_W-1:0]             out_distance,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [CFG_IDX_W-1:0]          cfg_index,
  input  logic [CFG_W-1:0]              cfg_data
);

  localparam int ES = (COORD_WIDTH + 1 > 26) ? COORD_WIDTH + 1 - 26 : 0;
  localparam int DS = ES + DIR_WIDTH - 2;
  localparam int RW = DOT_W + DS + DIST_W;

  logic busy_r;
  logic [CFG_W-1:0] eps_r, min_r;
  logic signed [COORD_WIDTH-1:0] corner_r [9];
  logic signed [COORD_WIDTH-1:0] org [3];
  logic signed [DIR_WIDTH-1:0]   dir [3];
  logic accept, load, ray;

  geom_res_t geom;
  div_res_t  dres;

  logic signed [DOT_W-1:0] aa, un, vn, tn, uv;
  logic                    neg, miss;
  logic [RW-1:0]           num, den_sh;

  logic             t_vld_r, t_pass_r, t_sat_r;
  logic [RW-1:0]    t_num_r;
  logic [DOT_W-1:0] t_den_r;

  logic              out_valid_r, out_hit_r;
  logic [DIST_W-1:0] out_dist_r;
  logic              hit_nxt;

  assign busy      = busy_r;
  assign cfg_ready = 1'b1;
  assign accept    = start && !busy_r;
  assign load      = accept && (action_t'(in_action) == ACT_LOAD) &&
                     (in_corner_slot != SLOT_NONE);
  assign ray       = accept && (action_t'(in_action) == ACT_RAY);

  assign org[0] = in_point_x;
  assign org[1] = in_point_y;
  assign org[2] = in_point_z;
  assign dir[0] = in_dir_x;
  assign dir[1] = in_dir_y;
  assign dir[2] = in_dir_z;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
      eps_r  <= CFG_W'(1);
      min_r  <= CFG_W'(1);
      for (int i = 0; i < 9; i++) corner_r[i] <= '0;
    end else begin
      busy_r <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_reg_t'(cfg_index))
          REG_PARALLEL_EPS: eps_r <= cfg_data;
          REG_MIN_DIST:     min_r <= cfg_data;
          default: ;
        endcase
      end
      if (load) begin
        for (int ax = 0; ax < 3; ax++) begin
          corner_r[4'(3*in_corner_slot + ax)] <= org[ax];
        end
      end
    end
  end

  rti_geom #(
    .CW (COORD_WIDTH),
    .DW (DIR_WIDTH)
  ) u_geom (
    .clk      (clk),
    .rst_n    (rst_n),
    .vld_i    (ray),
    .corner_i (corner_r),
    .org_i    (org),
    .dir_i    (dir),
    .res_o    (geom)
  );

  // Flip all signs when the determinant is negative, then range tests.
  always_comb begin
    neg    = geom.a[DOT_W-1];
    aa     = neg ? -geom.a  : geom.a;
    un     = neg ? -geom.un : geom.un;
    vn     = neg ? -geom.vn : geom.vn;
    tn     = neg ? -geom.tn : geom.tn;
    uv     = un + vn;
    miss   = (aa == '0) || (aa < $signed({{(DOT_W-CFG_W){1'b0}}, eps_r})) ||
             (un < 0) || (un > aa) || (vn < 0) || (uv > aa) || (tn < 0);
    num    = RW'(unsigned'(tn)) << DS;
    den_sh = RW'(unsigned'(aa)) << DIST_W;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      t_vld_r <= 1'b0;
    end else begin
      t_vld_r <= geom.vld;
    end
  end

  always_ff @(posedge clk) begin
    t_pass_r <= !miss;
    t_sat_r  <= (num >= den_sh);
    t_num_r  <= num;
    t_den_r  <= unsigned'(aa);
  end

  rti_div #(
    .RW (RW)
  ) u_div (
    .clk    (clk),
    .rst_n  (rst_n),
    .vld_i  (t_vld_r),
    .pass_i (t_pass_r),
    .sat_i  (t_sat_r),
    .num_i  (t_num_r),
    .den_i  (t_den_r),
    .res_o  (dres)
  );

  assign hit_nxt = dres.pass && (dres.quo > DIST_W'(min_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      out_hit_r   <= 1'b0;
    end else begin
      out_valid_r <= dres.vld;
      out_hit_r   <= dres.vld && hit_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_dist_r <= (dres.vld && hit_nxt) ? dres.quo : '0;
  end

  assign out_valid    = out_valid_r;
  assign out_hit      = out_hit_r;
  assign out_distance = out_dist_r;

endmodule

[rtl/core/rti_geom.sv]
// Edge, cross product and dot product pipeline of the ray/triangle test.
module rti_geom import rti_pkg::*; #(
  parameter int CW = 24,
  parameter int DW = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 vld_i,
  input  logic signed [CW-1:0] corner_i [9],
  input  logic signed [CW-1:0] org_i [3],
  input  logic signed [DW-1:0] dir_i [3],
  output geom_res_t            res_o
);

  localparam int ES   = (CW + 1 > 26) ? CW + 1 - 26 : 0;
  localparam int EW   = CW + 1 - ES;
  localparam int PH   = DW + EW;
  localparam int PQ   = 2 * EW;
  localparam int CMAX = (PH > PQ) ? PH : PQ;
  localparam int CS   = (CMAX > 36) ? CMAX - 36 : 0;
  localparam int HW   = PH + 1 - CS;
  localparam int QW   = PQ + 1 - CS;

  logic [GEOM_STAGES-1:0] vld_r;

  logic signed [EW-1:0] e1_r [3], e2_r [3], s_r [3];
  logic signed [DW-1:0] d_r  [3];
  logic signed [EW-1:0] e1b_r [3], e2b_r [3], sb_r [3];
  logic signed [DW-1:0] db_r  [3];
  logic signed [EW-1:0] e1c_r [3], e2c_r [3], sc_r [3];
  logic signed [DW-1:0] dc_r  [3];
  logic signed [PH-1:0] ph_r [6];
  logic signed [PQ-1:0] pq_r [6];
  logic signed [HW-1:0] h_r [3];
  logic signed [QW-1:0] q_r [3];
  logic signed [DOT_W-1:0] pa_r [3], pu_r [3], pv_r [3], pt_r [3];
  logic signed [DOT_W-1:0] a_r, un_r, vn_r, tn_r;

  logic signed [CW:0]   dif1 [3], dif2 [3], difs [3];
  logic signed [PH:0]   dh [3];
  logic signed [PQ:0]   dq [3];

  always_comb begin
    for (int ax = 0; ax < 3; ax++) begin
      dif1[ax] = (CW+1)'(corner_i[3+ax]) - (CW+1)'(corner_i[ax]);
      dif2[ax] = (CW+1)'(corner_i[6+ax]) - (CW+1)'(corner_i[ax]);
      difs[ax] = (CW+1)'(org_i[ax]) - (CW+1)'(corner_i[ax]);
    end
    for (int k = 0; k < 3; k++) begin
      dh[k] = (PH+1)'(ph_r[2*k]) - (PH+1)'(ph_r[2*k+1]);
      dq[k] = (PQ+1)'(pq_r[2*k]) - (PQ+1)'(pq_r[2*k+1]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[GEOM_STAGES-2:0], vld_i};
    end
  end

  always_ff @(posedge clk) begin
    for (int ax = 0; ax < 3; ax++) begin
      // stage 1: edges and origin offset, floor-reduced
      e1_r[ax] <= EW'(dif1[ax] >>> ES);
      e2_r[ax] <= EW'(dif2[ax] >>> ES);
      s_r[ax]  <= EW'(difs[ax] >>> ES);
      d_r[ax]  <= dir_i[ax];
      e1b_r[ax] <= e1_r[ax];
      e2b_r[ax] <= e2_r[ax];
      sb_r[ax]  <= s_r[ax];
      db_r[ax]  <= d_r[ax];
      e1c_r[ax] <= e1b_r[ax];
      e2c_r[ax] <= e2b_r[ax];
      sc_r[ax]  <= sb_r[ax];
      dc_r[ax]  <= db_r[ax];
    end
    // stage 2: cross product terms, h = d x e2, q = s x e1
    ph_r[0] <= d_r[1] * e2_r[2];
    ph_r[1] <= d_r[2] * e2_r[1];
    ph_r[2] <= d_r[2] * e2_r[0];
    ph_r[3] <= d_r[0] * e2_r[2];
    ph_r[4] <= d_r[0] * e2_r[1];
    ph_r[5] <= d_r[1] * e2_r[0];
    pq_r[0] <= s_r[1] * e1_r[2];
    pq_r[1] <= s_r[2] * e1_r[1];
    pq_r[2] <= s_r[2] * e1_r[0];
    pq_r[3] <= s_r[0] * e1_r[2];
    pq_r[4] <= s_r[0] * e1_r[1];
    pq_r[5] <= s_r[1] * e1_r[0];
    // stage 3: differences, floor-reduced
    for (int k = 0; k < 3; k++) begin
      h_r[k] <= HW'(dh[k] >>> CS);
      q_r[k] <= QW'(dq[k] >>> CS);
    end
    // stage 4: dot product terms
    for (int ax = 0; ax < 3; ax++) begin
      pa_r[ax] <= DOT_W'(e1c_r[ax] * h_r[ax]);
      pu_r[ax] <= DOT_W'(sc_r[ax] * h_r[ax]);
      pv_r[ax] <= DOT_W'(dc_r[ax] * q_r[ax]);
      pt_r[ax] <= DOT_W'(e2c_r[ax] * q_r[ax]);
    end
    // stage 5: sums
    a_r  <= pa_r[0] + pa_r[1] + pa_r[2];
    un_r <= pu_r[0] + pu_r[1] + pu_r[2];
    vn_r <= pv_r[0] + pv_r[1] + pv_r[2];
    tn_r <= pt_r[0] + pt_r[1] + pt_r[2];
  end

  assign res_o.vld = vld_r[GEOM_STAGES-1];
  assign res_o.a   = a_r;
  assign res_o.un  = un_r;
  assign res_o.vn  = vn_r;
  assign res_o.tn  = tn_r;

endmodule

[rtl/core/rti_div.sv]
// Restoring divider, one quotient bit per pipeline stage, for the hit distance.
module rti_div import rti_pkg::*; #(
  parameter int RW = 102
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             vld_i,
  input  logic             pass_i,
  input  logic             sat_i,
  input  logic [RW-1:0]    num_i,
  input  logic [DOT_W-1:0] den_i,
  output div_res_t         res_o
);

  logic              vld_r  [DIV_STAGES];
  logic              pass_r [DIV_STAGES];
  logic              sat_r  [DIV_STAGES];
  logic [RW-1:0]     rem_r  [DIV_STAGES];
  logic [DOT_W-1:0]  den_r  [DIV_STAGES];
  logic [DIST_W-1:0] quo_r  [DIV_STAGES];

  for (genvar k = 0; k < DIV_STAGES; k++) begin : g_st
    logic              v_in, p_in, s_in, ge;
    logic [RW-1:0]     r_in, dsh;
    logic [DOT_W-1:0]  d_in;
    logic [DIST_W-1:0] q_in;

    if (k == 0) begin : g_first
      assign v_in = vld_i;
      assign p_in = pass_i;
      assign s_in = sat_i;
      assign r_in = num_i;
      assign d_in = den_i;
      assign q_in = '0;
    end else begin : g_next
      assign v_in = vld_r[k-1];
      assign p_in = pass_r[k-1];
      assign s_in = sat_r[k-1];
      assign r_in = rem_r[k-1];
      assign d_in = den_r[k-1];
      assign q_in = quo_r[k-1];
    end

    assign dsh = RW'(d_in) << (DIST_W - 1 - k);
    assign ge  = (r_in >= dsh);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else begin
        vld_r[k] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      pass_r[k] <= p_in;
      sat_r[k]  <= s_in;
      den_r[k]  <= d_in;
      rem_r[k]  <= ge ? r_in - dsh : r_in;
      quo_r[k]  <= ge ? (q_in | (DIST_W'(1) << (DIST_W - 1 - k))) : q_in;
    end
  end

  assign res_o.vld  = vld_r[DIV_STAGES-1];
  assign res_o.pass = pass_r[DIV_STAGES-1];
  assign res_o.quo  = sat_r[DIV_STAGES-1] ? '1 : quo_r[DIV_STAGES-1];

endmodule

[rtl/core/rti_checker.sv]
// Port-level checker for the ray/triangle block and its bind.
`include "ray_triangle_intersect_defines.svh"

module rti_checker import rti_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              start,
  input logic              busy,
  input logic              in_action,
  input logic              out_valid,
  input logic              out_hit,
  input logic [DIST_W-1:0] out_distance
);

  `RTI_ASSERT_DELAY(a_ray_gives_result, clk, rst_n, start && !busy && in_action, LATENCY, out_valid, "ray transaction gave no result")
  `RTI_ASSERT_IMPL(a_result_from_ray, clk, rst_n, out_valid, $past(start && !busy && in_action, LATENCY), "result without a ray transaction")
  `RTI_ASSERT_IMPL(a_miss_zero, clk, rst_n, out_valid && !out_hit, out_distance == '0, "miss with nonzero distance")
  `RTI_ASSERT_IMPL(a_hit_valid, clk, rst_n, out_hit, out_valid && (out_distance != '0), "hit outside a result or at zero distance")

endmodule

bind ray_triangle_intersect rti_checker u_rti_checker (.*);

[tb/ray_triangle_intersect_checker.sv]
// Checker for the ray/triangle block: predicts each ray result and compares it.
`timescale 1ns / 100ps
module ray_triangle_intersect_checker import rti_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic                     busy,
  input  logic                     in_action,
  input  logic [SLOT_W-1:0]        in_corner_slot,
  input  logic signed [23:0]       in_point_x,
  input  logic signed [23:0]       in_point_y,
  input  logic signed [23:0]       in_point_z,
  input  logic signed [15:0]       in_dir_x,
  input  logic signed [15:0]       in_dir_y,
  input  logic signed [15:0]       in_dir_z,
  input  logic                     out_valid,
  input  logic                     out_hit,
  input  logic [DIST_W-1:0]        out_distance,
  input  logic                     cfg_valid,
  input  logic                     cfg_ready,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [CFG_W-1:0]         cfg_data,
  output int                       mismatch_count,
  output int                       pending_count
);

  localparam int CROSS_SHIFT = 14;
  localparam int DIST_SHIFT  = 14;
  localparam logic [127:0] DIST_SAT = 128'hFF_FFFF;

  logic signed [23:0] corner_mem [3][3];
  logic [CFG_W-1:0]   parallel_eps;
  logic [CFG_W-1:0]   min_dist;
  logic               hit_q  [$];
  logic [DIST_W-1:0]  dist_q [$];

  task automatic report_mismatch(input string what, input longint exp_v, input longint got_v);
    $display("%0t: %s mismatch: expected %0d got %0d", $time, what, exp_v, got_v);
    mismatch_count++;
  endtask

  // Integer intersection test, with the cross products floor-reduced, against the stored triangle.
  function automatic void intersect_ray(
    input  logic signed [23:0] ox, oy, oz,
    input  logic signed [15:0] dx, dy, dz,
    output logic               hit,
    output logic [DIST_W-1:0]  dist_o
  );
    longint c0 [3], e1 [3], e2 [3], s [3], d [3], h [3], q [3];
    longint org [3];
    longint a, un, vn, tn;
    logic [127:0] quo;
    org[0] = ox; org[1] = oy; org[2] = oz;
    d[0] = dx; d[1] = dy; d[2] = dz;
    for (int ax = 0; ax < 3; ax++) begin
      c0[ax] = corner_mem[0][ax];
      e1[ax] = longint'(corner_mem[1][ax]) - c0[ax];
      e2[ax] = longint'(corner_mem[2][ax]) - c0[ax];
      s[ax]  = org[ax] - c0[ax];
    end
    h[0] = (d[1] * e2[2] - d[2] * e2[1]) >>> CROSS_SHIFT;
    h[1] = (d[2] * e2[0] - d[0] * e2[2]) >>> CROSS_SHIFT;
    h[2] = (d[0] * e2[1] - d[1] * e2[0]) >>> CROSS_SHIFT;
    q[0] = (s[1] * e1[2] - s[2] * e1[1]) >>> CROSS_SHIFT;
    q[1] = (s[2] * e1[0] - s[0] * e1[2]) >>> CROSS_SHIFT;
    q[2] = (s[0] * e1[1] - s[1] * e1[0]) >>> CROSS_SHIFT;
    a  = e1[0] * h[0] + e1[1] * h[1] + e1[2] * h[2];
    un = s[0] * h[0] + s[1] * h[1] + s[2] * h[2];
    vn = d[0] * q[0] + d[1] * q[1] + d[2] * q[2];
    tn = e2[0] * q[0] + e2[1] * q[1] + e2[2] * q[2];
    if (a < 0) begin
      a = -a; un = -un; vn = -vn; tn = -tn;
    end
    hit    = 1'b0;
    dist_o = '0;
    if (a == 0 || a < longint'(parallel_eps)) return;
    if (un < 0 || un > a || vn < 0 || un + vn > a || tn < 0) return;
    quo = ({64'd0, tn} << DIST_SHIFT) / {64'd0, a};
    if (quo > DIST_SAT) quo = DIST_SAT;
    if (quo[DIST_W-1:0] > DIST_W'(min_dist)) begin
      hit    = 1'b1;
      dist_o = quo[DIST_W-1:0];
    end
  endfunction

  always @(posedge clk) begin
    logic             exp_hit;
    logic [DIST_W-1:0] exp_dist;
    if (!rst_n) begin
      for (int k = 0; k < 3; k++)
        for (int ax = 0; ax < 3; ax++) corner_mem[k][ax] = '0;
      parallel_eps = 16'd1;
      min_dist     = 16'd1;
      hit_q.delete();
      dist_q.delete();
      mismatch_count = 0;
    end else begin
      if (out_valid) begin
        if (hit_q.size() == 0) begin
          report_mismatch("unexpected result", 0, 1);
        end else begin
          exp_hit  = hit_q.pop_front();
          exp_dist = dist_q.pop_front();
          if (out_hit !== exp_hit) report_mismatch("hit", exp_hit, out_hit);
          if (out_distance !== exp_dist) report_mismatch("distance", exp_dist, out_distance);
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_PARALLEL_EPS: parallel_eps = cfg_data;
          REG_MIN_DIST:     min_dist     = cfg_data;
          default: ;
        endcase
      end
      if (start && !busy) begin
        if (in_action == ACT_RAY) begin
          intersect_ray(in_point_x, in_point_y, in_point_z, in_dir_x, in_dir_y, in_dir_z,
                        exp_hit, exp_dist);
          hit_q  = {hit_q, exp_hit};
          dist_q = {dist_q, exp_dist};
        end else if (in_corner_slot != SLOT_NONE) begin
          corner_mem[in_corner_slot][0] = in_point_x;
          corner_mem[in_corner_slot][1] = in_point_y;
          corner_mem[in_corner_slot][2] = in_point_z;
        end
      end
    end
    pending_count = hit_q.size();
  end

endmodule

[tb/ray_triangle_intersect_tb.sv]
// Testbench top: drives loads, rays and register writes and gives the verdict.
`timescale 1ns / 100ps
module ray_triangle_intersect_tb;
  import rti_pkg::*;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int ITEM_TARGET    = 650;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  logic clk, rst_n;
  logic start, busy, busy_s;
  logic in_action;
  logic [SLOT_W-1:0] in_corner_slot;
  logic signed [23:0] in_point_x, in_point_y, in_point_z;
  logic signed [15:0] in_dir_x, in_dir_y, in_dir_z;
  logic out_valid, out_hit;
  logic [DIST_W-1:0] out_distance;
  logic cfg_valid, cfg_ready, cfg_ready_s;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0] cfg_data;
  int mismatch_count, pending_count;
  int item_count, idle_cycles;
  bit no_gaps;

  ray_triangle_intersect u_dut (.*);

  ray_triangle_intersect_checker u_checker (.*);

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // busy and cfg_ready only change at rising edges; sample them mid-cycle
  always @(negedge clk) begin
    busy_s      <= busy;
    cfg_ready_s <= cfg_ready;
  end

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || (cfg_valid && cfg_ready) || out_valid)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  function automatic int gap_cycles();
    int r;
    if (no_gaps) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic send_item(input action_t act, input logic [SLOT_W-1:0] slot,
                           input logic signed [23:0] px, py, pz,
                           input logic signed [15:0] dx, dy, dz);
    int gap;
    start          <= 1'b1;
    in_action      <= act;
    in_corner_slot <= slot;
    in_point_x <= px; in_point_y <= py; in_point_z <= pz;
    in_dir_x   <= dx; in_dir_y   <= dy; in_dir_z   <= dz;
    do @(posedge clk); while (busy_s);
    item_count++;
    gap = gap_cycles();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic load_corner(input logic [SLOT_W-1:0] slot,
                             input logic signed [23:0] px, py, pz);
    send_item(ACT_LOAD, slot, px, py, pz, 16'($urandom), 16'($urandom), 16'($urandom));
  endtask

  task automatic cast_ray(input logic signed [23:0] px, py, pz,
                          input logic signed [15:0] dx, dy, dz);
    send_item(ACT_RAY, 2'($urandom), px, py, pz, dx, dy, dz);
  endtask

  // Drain everything in flight, then write one register.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
    start <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready_s);
    cfg_valid <= 1'b0;
  endtask

  task automatic unit_triangle(input int size);
    load_corner(2'd0, 24'sd0, 24'sd0, 24'sd0);
    load_corner(2'd1, 24'(size), 24'sd0, 24'sd0);
    load_corner(2'd2, 24'sd0, 24'(size), 24'sd0);
  endtask

  // Triangle in a z plane, ray from below through its interior, mostly.
  task automatic aimed_burst();
    logic signed [23:0] x0, y0, z0, ox, oy;
    int size, u, v, nrays;
    bit flip;
    x0 = 24'($signed($urandom_range(0, 1 << 21)) - (1 << 20));
    y0 = 24'($signed($urandom_range(0, 1 << 21)) - (1 << 20));
    z0 = 24'($signed($urandom_range(0, 1 << 21)) - (1 << 20));
    size = $urandom_range(1, 1 << $urandom_range(1, 18));
    flip = $urandom_range(0, 1);
    load_corner(2'd0, x0, y0, z0);
    load_corner(flip ? 2'd2 : 2'd1, x0 + 24'(size), y0, z0);
    load_corner(flip ? 2'd1 : 2'd2, x0, y0 + 24'(size), z0);
    nrays = $urandom_range(1, 6);
    for (int i = 0; i < nrays; i++) begin
      u  = $urandom_range(0, size);
      v  = $urandom_range(0, size - u);
      ox = x0 + 24'(u);
      oy = y0 + 24'(v);
      cast_ray(ox, oy, z0 - 24'($urandom_range(0, 1 << $urandom_range(0, 20))),
               16'($signed($urandom_range(0, 512)) - 256),
               16'($signed($urandom_range(0, 512)) - 256),
               ($urandom_range(0, 9) == 0) ? -16'($urandom_range(1, 32767))
                                           : 16'($urandom_range(1, 32767)));
    end
  endtask

  task automatic noise_item();
    send_item(action_t'($urandom_range(0, 1)), 2'($urandom), 24'($urandom), 24'($urandom),
              24'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
  endtask

  initial begin
    int phase;
    rst_n = 1'b0; start = 1'b0; in_action = ACT_LOAD; in_corner_slot = '0;
    in_point_x = '0; in_point_y = '0; in_point_z = '0;
    in_dir_x = '0; in_dir_y = '0; in_dir_z = '0;
    cfg_valid = 1'b0; cfg_index = REG_PARALLEL_EPS; cfg_data = '0;
    item_count = 0; no_gaps = 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty store, hits, parallel, behind origin, extremes
    cast_ray(24'sd10, 24'sd10, -24'sd100, 16'sd0, 16'sd0, 16'sd16384);
    unit_triangle(1024);
    cast_ray(24'sd100, 24'sd100, -24'sd512, 16'sd0, 16'sd0, 16'sd16384);
    cast_ray(24'sd100, 24'sd100, -24'sd512, 16'sd0, 16'sd0, 16'sh7FFF);
    cast_ray(24'sd100, 24'sd100, -24'sd512, 16'sd0, 16'sd0, 16'sd1);
    cast_ray(24'sd100, 24'sd100, 24'sd0, 16'sd0, 16'sd0, 16'sd16384);
    cast_ray(24'sd100, 24'sd100, 24'sd512, 16'sd0, 16'sd0, 16'sd16384);
    cast_ray(24'sd100, 24'sd100, -24'sd512, 16'sd16384, 16'sd0, 16'sd0);
    cast_ray(24'sd2000, 24'sd100, -24'sd512, 16'sd0, 16'sd0, 16'sd16384);
    cast_ray(24'sd0, 24'sd0, -24'sd512, 16'sd0, 16'sd0, -16'sh8000);
    cast_ray(24'sh7FFFFF, -24'sh800000, 24'sh7FFFFF, 16'sh7FFF, -16'sh8000, 16'sh7FFF);
    load_corner(SLOT_NONE, 24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF);
    cast_ray(24'sd512, 24'sd0, -24'sd256, 16'sd0, 16'sd0, 16'sd16384);
    load_corner(2'd1, -24'sh800000, 24'sh7FFFFF, -24'sh800000);
    load_corner(2'd2, 24'sh7FFFFF, -24'sh800000, 24'sh7FFFFF);
    cast_ray(-24'sh800000, -24'sh800000, -24'sh800000, -16'sh8000, 16'sh7FFF, -16'sh8000);
    load_corner(2'd1, 24'sd1024, 24'sd0, 24'sd0);
    load_corner(2'd2, 24'sd2048, 24'sd0, 24'sd0);
    cast_ray(24'sd10, 24'sd0, -24'sd100, 16'sd0, 16'sd0, 16'sd16384);

    write_reg(REG_PARALLEL_EPS, 16'd0);
    write_reg(REG_MIN_DIST, 16'd0);
    write_reg(REG_UNUSED, 16'hFFFF);
    cast_ray(24'sd10, 24'sd0, -24'sd100, 16'sd0, 16'sd0, 16'sd16384);
    unit_triangle(1024);
    cast_ray(24'sd100, 24'sd100, 24'sd0, 16'sd0, 16'sd0, 16'sd16384);

    phase = 0;
    while (item_count < ITEM_TARGET) begin
      if (item_count > 130 * (phase + 1)) begin
        phase++;
        case (phase % 4)
          0: begin write_reg(REG_PARALLEL_EPS, 16'd1); write_reg(REG_MIN_DIST, 16'd1); end
          1: begin write_reg(REG_PARALLEL_EPS, 16'hFFFF); write_reg(REG_MIN_DIST, 16'hFFFF); end
          2: begin
            write_reg(REG_PARALLEL_EPS, 16'($urandom));
            write_reg(REG_MIN_DIST, 16'($urandom));
          end
          default: begin write_reg(REG_PARALLEL_EPS, 16'd0); write_reg(REG_MIN_DIST, 16'd0); end
        endcase
      end
      no_gaps = ($urandom_range(0, 4) == 0);
      if ($urandom_range(0, 9) < 7) aimed_burst();
      else noise_item();
    end

    start <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
    if (mismatch_count == 0 && pending_count == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule

[ray_triangle_intersect.f]
+incdir+rtl/core
rtl/core/rti_pkg.sv
rtl/core/rti_geom.sv
rtl/core/rti_div.sv
rtl/core/ray_triangle_intersect.sv
rtl/core/rti_checker.sv
tb/ray_triangle_intersect_checker.sv
tb/ray_triangle_intersect_tb.sv
